>>> src/assert_macros.svh
// Assertion macros shared by the configuration space block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PCICFG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcicfg same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PCICFG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcicfg next-cycle check failed");

`endif

>>> src/pcicfg_pkg.sv
// Types, constants and reset identity table of the PCI configuration space block.
`timescale 1ns / 1ps
package pcicfg_pkg;

	typedef struct packed {
		logic        req_type;
		logic [31:0] config_address;
		logic [1:0]  byte_lane;
		logic [7:0]  write_byte;
	} cfg_req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [31:0] display_memory_base;
		logic [31:0] display_io_base;
	} cfg_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} pcicfg_cmd_t;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [4:0] DEV_HOST    = 5'h00;
	localparam logic [4:0] DEV_IO      = 5'h10;
	localparam logic [4:0] DEV_DISPLAY = 5'h12;

	localparam logic [1:0] SLOT_HOST    = 2'd0;
	localparam logic [1:0] SLOT_IO      = 2'd1;
	localparam logic [1:0] SLOT_DISPLAY = 2'd2;

	localparam logic [7:0] REG_RO_END    = 8'h08;
	localparam logic [7:0] REG_BAR_FIRST = 8'h10;
	localparam logic [7:0] REG_BAR_LAST  = 8'h27;

	localparam logic [5:0] DW_BAR0 = 6'd4;
	localparam logic [5:0] DW_BAR1 = 6'd5;
	localparam logic [5:0] DW_BAR2 = 6'd6;

	localparam logic [31:0] IO_BAR0_MASK   = 32'hFFF8_0000;
	localparam logic [31:0] DISP_BAR1_MASK = 32'hFFFF_FF01;
	localparam logic [31:0] DISP_BAR2_MASK = 32'hFFFF_F000;
	localparam logic [31:0] IO_BASE_MASK   = 32'hFFFF_FF00;

	localparam logic [7:0]  READ_MISS     = 8'hFF;
	localparam logic [7:0]  READ_BEYOND   = 8'h00;
	localparam logic [31:0] BAR1_RESET    = 32'h0000_0001;

	// Dword of a device's configuration space as it stands after reset.
	function automatic logic [31:0] reset_dword(input logic [1:0] slot, input logic [5:0] dw);
		logic [31:0] val;
		val = 32'h0;
		case ({slot, dw})
			{SLOT_HOST, 6'd0}:     val = 32'h0002_1057;
			{SLOT_HOST, 6'd1}:     val = 32'h0080_0006;
			{SLOT_HOST, 6'd2}:     val = 32'h0600_0040;
			{SLOT_IO, 6'd0}:       val = 32'h0010_106B;
			{SLOT_IO, 6'd1}:       val = 32'h0000_0006;
			{SLOT_IO, 6'd2}:       val = 32'hFF00_0001;
			{SLOT_IO, 6'd4}:       val = 32'hF300_0000;
			{SLOT_IO, 6'd15}:      val = 32'h0000_0100;
			{SLOT_DISPLAY, 6'd0}:  val = 32'h4750_1002;
			{SLOT_DISPLAY, 6'd1}:  val = 32'h0280_0006;
			{SLOT_DISPLAY, 6'd2}:  val = 32'h0300_005C;
			{SLOT_DISPLAY, 6'd5}:  val = 32'h0000_0001;
			{SLOT_DISPLAY, 6'd11}: val = 32'h4750_1002;
			{SLOT_DISPLAY, 6'd15}: val = 32'h0000_0100;
			default:               val = 32'h0;
		endcase
		return val;
	endfunction

endpackage

>>> src/pcicfg_ctrl.sv
// Controller state machine: sequences the read and write-back cycles of one access.
`timescale 1ns / 1ps
module pcicfg_ctrl import pcicfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	output pcicfg_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_ACCESS = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		cmd.capture = start && (state_q == ST_IDLE);
		cmd.commit  = (state_q == ST_ACCESS);
		state_d     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.commit;
		end
	end

	assign busy = (state_q == ST_ACCESS);
	assign done = done_q;

endmodule

>>> src/pcicfg_dp.sv
// Datapath: address decode, dword-wide configuration memory, BAR merge and base shadows.
`timescale 1ns / 1ps
module pcicfg_dp import pcicfg_pkg::*; #(
	parameter int CONFIG_BYTES_PER_DEVICE = 256,
	parameter int DISPLAY_APERTURE_LOG2   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pcicfg_cmd_t cmd,
	input  cfg_req_t    req,
	output cfg_rsp_t    rsp
);

	localparam int RowsPerDev = (CONFIG_BYTES_PER_DEVICE + 3) / 4;
	localparam int RowCount   = 3 * RowsPerDev;
	localparam int RowW       = $clog2(RowCount);
	localparam logic [31:0] ApertureMask = ~((32'd1 << DISPLAY_APERTURE_LOG2) - 32'd1);

	// Decode of the incoming request.
	logic [7:0]      reg_in;
	logic [4:0]      dev_in;
	logic [1:0]      slot_in;
	logic            present_in;
	logic            hit_in;
	logic            range_in;
	logic [RowW-1:0] row_in;

	// First-stage request registers.
	logic            write_s1;
	logic            hit_s1;
	logic            range_s1;
	logic [1:0]      slot_s1;
	logic [7:0]      reg_s1;
	logic [1:0]      lane_s1;
	logic [7:0]      wbyte_s1;
	logic [RowW-1:0] row_s1;
	logic [31:0]     rdata_s1;

	logic [31:0] mem_q [RowCount];
	logic        valid_q [RowCount];
	logic [31:0] bar0_q;
	logic [31:0] bar1_q;
	cfg_rsp_t    rsp_q;

	logic [31:0] cur_row;
	logic [31:0] merged;
	logic [31:0] mask_dw;
	logic [7:0]  mask_byte;
	logic [7:0]  old_byte;
	logic [7:0]  rbyte;
	logic        wr_en;
	logic [31:0] bar0_new;
	logic [31:0] bar1_new;

	function automatic logic [31:0] bar_mask(input logic [1:0] slot, input logic [5:0] dw);
		logic [31:0] m;
		m = 32'h0;
		if (slot == SLOT_IO && dw == DW_BAR0) begin
			m = IO_BAR0_MASK;
		end else if (slot == SLOT_DISPLAY) begin
			if (dw == DW_BAR0) begin
				m = ApertureMask;
			end else if (dw == DW_BAR1) begin
				m = DISP_BAR1_MASK;
			end else if (dw == DW_BAR2) begin
				m = DISP_BAR2_MASK;
			end
		end
		return m;
	endfunction

	always_comb begin
		reg_in  = {req.config_address[7:2], req.byte_lane};
		dev_in  = req.config_address[15:11];
		slot_in = SLOT_HOST;
		present_in = 1'b1;
		case (dev_in)
			DEV_HOST:    slot_in = SLOT_HOST;
			DEV_IO:      slot_in = SLOT_IO;
			DEV_DISPLAY: slot_in = SLOT_DISPLAY;
			default:     present_in = 1'b0;
		endcase
		hit_in   = req.config_address[31] && (req.config_address[23:16] == 8'h00) && present_in;
		range_in = ({1'b0, reg_in} < 9'(CONFIG_BYTES_PER_DEVICE));
		if (slot_in == SLOT_DISPLAY) begin
			row_in = RowW'(2 * RowsPerDev) + RowW'(reg_in[7:2]);
		end else if (slot_in == SLOT_IO) begin
			row_in = RowW'(RowsPerDev) + RowW'(reg_in[7:2]);
		end else begin
			row_in = RowW'(reg_in[7:2]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			write_s1 <= (req.req_type == REQ_WRITE);
			hit_s1   <= hit_in;
			range_s1 <= range_in;
			slot_s1  <= slot_in;
			reg_s1   <= reg_in;
			lane_s1  <= req.byte_lane;
			wbyte_s1 <= req.write_byte;
			row_s1   <= row_in;
		end
	end

	// Configuration memory: one read port, one write port, registered read data.
	always_ff @(posedge clk) begin
		if (cmd.capture && hit_in && range_in) begin
			rdata_s1 <= mem_q[row_in];
		end
		if (wr_en) begin
			mem_q[row_s1] <= merged;
		end
	end

	// A row never written reads as its reset identity value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RowCount; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[row_s1] <= 1'b1;
		end
	end

	always_comb begin
		cur_row   = valid_q[row_s1] ? rdata_s1 : reset_dword(slot_s1, reg_s1[7:2]);
		old_byte  = cur_row[8*lane_s1 +: 8];
		mask_dw   = bar_mask(slot_s1, reg_s1[7:2]);
		if (reg_s1 inside {[REG_BAR_FIRST:REG_BAR_LAST]}) begin
			mask_byte = mask_dw[8*lane_s1 +: 8];
		end else begin
			mask_byte = 8'hFF;
		end
		merged = cur_row;
		merged[8*lane_s1 +: 8] = (wbyte_s1 & mask_byte) | (old_byte & ~mask_byte);
		wr_en = cmd.commit && write_s1 && hit_s1 && range_s1 && (reg_s1 >= REG_RO_END);

		if (write_s1) begin
			rbyte = 8'h00;
		end else if (!hit_s1) begin
			rbyte = READ_MISS;
		end else if (!range_s1) begin
			rbyte = READ_BEYOND;
		end else begin
			rbyte = old_byte;
		end

		bar0_new = bar0_q;
		bar1_new = bar1_q;
		if (wr_en && slot_s1 == SLOT_DISPLAY && reg_s1[7:2] == DW_BAR0) begin
			bar0_new = merged;
		end
		if (wr_en && slot_s1 == SLOT_DISPLAY && reg_s1[7:2] == DW_BAR1) begin
			bar1_new = merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar0_q <= 32'h0;
			bar1_q <= BAR1_RESET;
		end else begin
			bar0_q <= bar0_new;
			bar1_q <= bar1_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.read_byte           <= rbyte;
			rsp_q.display_memory_base <= bar0_new & ApertureMask;
			rsp_q.display_io_base     <= bar1_new & IO_BASE_MASK;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> src/pci_config_space_with_bar_sizing.sv
// Top level of the emulated PCI configuration space with BAR sizing for three devices.
//
//   Channel   Signals            Direction  Handshake
//   request   start, req         in         beat taken at a clock edge with start high, busy low
//   result    done, rsp          out        one-cycle strobe, no back-pressure
//
// An accepted beat reads its configuration dword from the memory at the capture edge
// (busy low at that edge, high during the next cycle) and merges and writes it back
// while busy is high; the block takes no new beat during that read-modify-write of one
// dword. The result beat appears on rsp with done high in the cycle after the write-back,
// while a new request may already be taken. Reset clears all row valid bits, so every
// dword reads its identity value until first written; there is no clearing pass. The
// receiver cannot stall the block.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pci_config_space_with_bar_sizing import pcicfg_pkg::*; #(
	parameter int CONFIG_BYTES_PER_DEVICE = 256,
	parameter int DISPLAY_APERTURE_LOG2   = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cfg_req_t req,
	output logic     done,
	output cfg_rsp_t rsp
);

	// Commands from the sequencer to the datapath: capture latches the request and
	// launches the memory read, commit performs the merge, write-back and result load.
	pcicfg_cmd_t cmd;

	pcicfg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	pcicfg_dp #(
		.CONFIG_BYTES_PER_DEVICE (CONFIG_BYTES_PER_DEVICE),
		.DISPLAY_APERTURE_LOG2   (DISPLAY_APERTURE_LOG2)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	// An accepted beat occupies exactly one busy cycle.
	`PCICFG_ASSERT_NXT(a_start_busy, start && !busy, busy)
	`PCICFG_ASSERT_NXT(a_busy_once, busy, !busy && done)
	// A result only follows a write-back cycle.
	`PCICFG_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	// The reported I/O base never carries its low byte.
	`PCICFG_ASSERT_IMP(a_io_base_align, done, rsp.display_io_base[7:0] == 8'h00)

endmodule
